// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the credential expiry table RTL.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante |-> cons");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: ante |=> cons");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/cet_pkg.sv -----
// Shared constants, status codes and controller/datapath command types
// for the credential expiry table. No dependencies.
package cet_pkg;

  localparam int ENTRIES    = 32;
  localparam int NAME_BYTES = 32;

  // Bytes of a name that can be significant; the last one is always the terminator
  localparam int KEY_BYTES = NAME_BYTES - 1;
  localparam int KEY_W     = KEY_BYTES * 8;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam int HASH_W = 64;
  localparam int DAY_W  = 32;

  // Input tdata layout, lowest bit first
  localparam int NAME_LSB    = 0;
  localparam int HASH_LSB    = 248;
  localparam int CHANGE_LSB  = 312;
  localparam int LIFE_LSB    = 344;
  localparam int TODAY_LSB   = 376;
  localparam int IN_TDATA_W  = 408;

  localparam int STATUS_W    = 3;
  localparam int OUT_TDATA_W = 8;

  localparam logic KIND_SET   = 1'b0;
  localparam logic KIND_CHECK = 1'b1;

  localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STS_ZERO_HASH = 3'd1;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] STS_MISMATCH  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_EXPIRED   = 3'd4;
  localparam logic [STATUS_W-1:0] STS_NO_RECORD = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [HASH_W-1:0] hash;
    logic [DAY_W-1:0]  change_day;
    logic [DAY_W-1:0]  lifetime;
  } rec_t;

  typedef struct packed {
    logic load;    // capture the input item
    logic canon;   // build the key, clear scan results
    logic scan;    // walk the table
    logic finish;  // decide, write back, post the result
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hdl/credential_expiry_table.sv -----
// Credential expiry table: one item at a time. After an item is accepted, the
// controller builds the key, scans the table and then decides; the decision can
// wait while the output register is full, and out_tvalid rises in the cycle after
// it. The next item can be taken in that same cycle. The scan reads one record per
// cycle from the record memory's read port. Reset (rst_n, synchronous, active low) clears the
// valid marks and control state at once; no clearing pass follows.
module credential_expiry_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // name_word_0, name_word_1, name_word_2, name_word_3, credential_hash,
  // change_day, lifetime_days, today
  input  logic [cet_pkg::IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status, zero filled to a byte
  output logic [cet_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cet_pkg::*;

  `include "assert_macros.svh"

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  cet_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  cet_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (dp_cmd),
    .sts        (dp_sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  `ASSERT_IMP(a_no_accept_in_scan, clk, rst_n, dp_cmd.scan, !in_tready)
  `ASSERT_IMP(a_finish_needs_room, clk, rst_n, dp_cmd.finish, dp_sts.out_free)
  `ASSERT_IMP(a_result_from_finish, clk, rst_n, $rose(out_tvalid), $past(dp_cmd.finish))
  `ASSERT_IMP(a_status_legal, clk, rst_n, out_tvalid, out_tdata[STATUS_W-1:0] <= STS_NO_RECORD)
  `ASSERT_NEXT(a_load_starts_work, clk, rst_n, in_tvalid && in_tready, dp_cmd.canon)

endmodule

// ----- hdl/cet_ctrl.sv -----
// Controller state machine for the credential expiry table.
// Uses cet_pkg; drives the datapath command struct.
module cet_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  cet_pkg::dp_sts_t  sts,
  output cet_pkg::dp_cmd_t  cmd
);
  import cet_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CANON  = 2'd1;
  localparam logic [1:0] ST_SCAN   = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // take no item while reset is held
  assign in_tready = rst_n && (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CANON;
        end
      end
      ST_CANON: begin
        cmd.canon = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- hdl/cet_dp.sv -----
// Datapath for the credential expiry table: item registers, key builder,
// record memory, scan unit, decision logic and output register. Uses cet_pkg.
module cet_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [cet_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  input  cet_pkg::dp_cmd_t               cmd,
  output cet_pkg::dp_sts_t               sts,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cet_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cet_pkg::*;

  // Item registers
  logic              kind_r;
  logic [KEY_W-1:0]  raw_r;
  logic [KEY_W-1:0]  key_r;
  logic [HASH_W-1:0] hash_r;
  logic [DAY_W-1:0]  change_r;
  logic [DAY_W-1:0]  life_r;
  logic [DAY_W-1:0]  today_r;

  // Table storage
  rec_t               rec_mem [ENTRIES];
  logic [ENTRIES-1:0] valid_r;

  // Scan unit
  logic [CNT_W-1:0]  cnt_r;
  logic              ev_r;
  logic [IDX_W-1:0]  eidx_r;
  rec_t              rd_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic              free_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [HASH_W-1:0] hit_hash_r;
  logic [DAY_W-1:0]  hit_change_r;
  logic [DAY_W-1:0]  hit_life_r;

  // Output register
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;

  // Key builder
  logic [KEY_BYTES-1:0] nz;
  logic [KEY_BYTES-1:0] keep;
  logic [KEY_W-1:0]     key_nxt;

  // Decision
  logic [DAY_W:0]      limit;
  logic [STATUS_W-1:0] status_nxt;
  logic                do_write;
  logic [IDX_W-1:0]    tgt_idx;
  logic                scan_rd;
  logic                slot_hit;

  // A byte survives only if it and every byte before it are nonzero:
  // nz + 1 turns the run of low ones into zeros, so the mask is that run.
  always_comb begin
    for (int b = 0; b < KEY_BYTES; b++) begin
      nz[b] = |raw_r[8*b +: 8];
    end
    keep = nz & ~(nz + KEY_BYTES'(1));
    for (int b = 0; b < KEY_BYTES; b++) begin
      key_nxt[8*b +: 8] = keep[b] ? raw_r[8*b +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_tuser;
      raw_r    <= in_tdata[NAME_LSB +: KEY_W];
      hash_r   <= in_tdata[HASH_LSB +: HASH_W];
      change_r <= in_tdata[CHANGE_LSB +: DAY_W];
      life_r   <= in_tdata[LIFE_LSB +: DAY_W];
      today_r  <= in_tdata[TODAY_LSB +: DAY_W];
    end
    if (cmd.canon) begin
      key_r <= key_nxt;
    end
  end

  assign scan_rd  = cmd.scan && (cnt_r < CNT_W'(ENTRIES));
  assign slot_hit = ev_r && valid_r[eidx_r] && (rd_r.key == key_r);

  // Record memory: one read port for the scan, one write port for write-back
  always_ff @(posedge clk) begin
    if (scan_rd) begin
      rd_r <= rec_mem[cnt_r[IDX_W-1:0]];
    end
    if (do_write) begin
      rec_mem[tgt_idx] <= '{key: key_r, hash: hash_r, change_day: change_r,
                            lifetime: life_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ev_r   <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (cmd.canon) begin
      cnt_r  <= '0;
      ev_r   <= 1'b0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else begin
      // evaluate the entry read in the previous cycle
      if (slot_hit && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (ev_r && !valid_r[eidx_r] && !free_r) begin
        free_r <= 1'b1;
      end
      ev_r <= scan_rd;
      if (scan_rd) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_rd) begin
      eidx_r <= cnt_r[IDX_W-1:0];
    end
    if (slot_hit && !hit_r) begin
      hit_idx_r    <= eidx_r;
      hit_hash_r   <= rd_r.hash;
      hit_change_r <= rd_r.change_day;
      hit_life_r   <= rd_r.lifetime;
    end
    if (ev_r && !valid_r[eidx_r] && !free_r) begin
      free_idx_r <= eidx_r;
    end
  end

  assign sts.scan_done = (cnt_r == CNT_W'(ENTRIES)) && !ev_r;
  assign sts.out_free  = !out_valid_r || out_tready;

  // Expiry limit is one bit wider than a day number, so it cannot wrap
  assign limit = {1'b0, hit_change_r} + {1'b0, hit_life_r};

  always_comb begin
    do_write   = 1'b0;
    tgt_idx    = hit_r ? hit_idx_r : free_idx_r;
    status_nxt = STS_OK;
    if (kind_r == KIND_SET) begin
      if (hash_r == '0) begin
        status_nxt = STS_ZERO_HASH;
      end else if (hit_r || free_r) begin
        status_nxt = STS_OK;
        do_write   = cmd.finish;
      end else begin
        status_nxt = STS_FULL;
      end
    end else begin
      if (!hit_r) begin
        status_nxt = STS_NO_RECORD;
      end else if (hit_hash_r != hash_r) begin
        status_nxt = STS_MISMATCH;
      end else if ((hit_life_r != '0) && ({1'b0, today_r} > limit)) begin
        status_nxt = STS_EXPIRED;
      end else begin
        status_nxt = STS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_write) begin
      valid_r[tgt_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - STATUS_W){1'b0}}, out_status_r};

endmodule

// ----- tb/tb_credential_expiry_table.sv -----
// Testbench for credential_expiry_table: directed and random set/check items,
// with a scoreboard that predicts each status from its own copy of the table.
// Depends on cet_pkg and the credential_expiry_table RTL.
`timescale 1ns / 100ps

import cet_pkg::*;

class cred_table_board;
  logic              slot_used [ENTRIES];
  logic [KEY_W-1:0]  slot_key  [ENTRIES];
  logic [HASH_W-1:0] slot_hash [ENTRIES];
  logic [DAY_W-1:0]  slot_day  [ENTRIES];
  logic [DAY_W-1:0]  slot_life [ENTRIES];
  logic [STATUS_W-1:0] expected_status [$];
  int errors;

  function new();
    errors = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;
  endfunction

  // Drop every byte from the first zero byte on.
  function logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] raw);
    logic [KEY_W-1:0] key;
    logic ended;
    key = '0;
    ended = 1'b0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (raw[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) key[8*b +: 8] = raw[8*b +: 8];
    end
    return key;
  endfunction

  function void note_item(input logic kind, input logic [IN_TDATA_W-1:0] data);
    logic [KEY_W-1:0]    key;
    logic [HASH_W-1:0]   hash;
    logic [DAY_W-1:0]    today;
    logic [DAY_W:0]      limit;
    logic [STATUS_W-1:0] sts;
    int hit, free_idx, s;
    key   = canon_key(data[NAME_LSB +: KEY_W]);
    hash  = data[HASH_LSB +: HASH_W];
    today = data[TODAY_LSB +: DAY_W];
    hit = -1;
    free_idx = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i]) begin
        if (hit < 0 && slot_key[i] == key) hit = i;
      end else if (free_idx < 0) begin
        free_idx = i;
      end
    end
    if (kind == KIND_SET) begin
      s = (hit >= 0) ? hit : free_idx;
      if (hash == '0) begin
        sts = STS_ZERO_HASH;
      end else if (s < 0) begin
        sts = STS_FULL;
      end else begin
        slot_used[s] = 1'b1;
        slot_key[s]  = key;
        slot_hash[s] = hash;
        slot_day[s]  = data[CHANGE_LSB +: DAY_W];
        slot_life[s] = data[LIFE_LSB +: DAY_W];
        sts = STS_OK;
      end
    end else begin
      if (hit < 0) begin
        sts = STS_NO_RECORD;
      end else begin
        // sum kept one bit wider so a late change day cannot wrap
        limit = {1'b0, slot_day[hit]} + {1'b0, slot_life[hit]};
        if (slot_hash[hit] != hash) sts = STS_MISMATCH;
        else if (slot_life[hit] != '0 && {1'b0, today} > limit) sts = STS_EXPIRED;
        else sts = STS_OK;
      end
    end
    expected_status.push_back(sts);
  endfunction

  function void check_result(input logic [OUT_TDATA_W-1:0] tdata);
    logic [STATUS_W-1:0] exp_sts;
    if (expected_status.size() == 0) begin
      $display("%0t: unexpected item, expected none, actual status %0d",
               $time, tdata[STATUS_W-1:0]);
      errors++;
    end else begin
      exp_sts = expected_status.pop_front();
      if (tdata[STATUS_W-1:0] !== exp_sts) begin
        $display("%0t: status mismatch, expected %0d, actual %0d",
                 $time, exp_sts, tdata[STATUS_W-1:0]);
        errors++;
      end
    end
  endfunction
endclass

module tb_credential_expiry_table;
  localparam int POOL = 40;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int idle_pct  = 0;
  int stall_pct = 0;

  logic [KEY_W-1:0]  pool_key   [POOL];
  int                pool_len   [POOL];
  logic              pool_known [POOL];
  logic [HASH_W-1:0] pool_hash  [POOL];
  logic [DAY_W-1:0]  pool_day   [POOL];
  logic [DAY_W-1:0]  pool_life  [POOL];

  cred_table_board board = new();

  credential_expiry_table uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  function automatic logic [KEY_W-1:0] rand_key();
    logic [255:0] r;
    for (int i = 0; i < 8; i++) r[32*i +: 32] = $urandom;
    return r[KEY_W-1:0];
  endfunction

  // Same name, with random junk after the terminator half the time.
  function automatic logic [KEY_W-1:0] present_name(input int idx);
    logic [KEY_W-1:0] junk;
    junk = rand_key() & ({KEY_W{1'b1}} << (8 * (pool_len[idx] + 1)));
    if ($urandom_range(0, 1) == 1) return pool_key[idx] | junk;
    return pool_key[idx];
  endfunction

  task automatic send_item(input logic kind, input logic [KEY_W-1:0] name,
                           input logic [HASH_W-1:0] hash, input logic [DAY_W-1:0] change,
                           input logic [DAY_W-1:0] life, input logic [DAY_W-1:0] today);
    logic [IN_TDATA_W-1:0] data;
    data = '0;
    data[NAME_LSB +: KEY_W]    = name;
    data[HASH_LSB +: HASH_W]   = hash;
    data[CHANGE_LSB +: DAY_W]  = change;
    data[LIFE_LSB +: DAY_W]    = life;
    data[TODAY_LSB +: DAY_W]   = today;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    board.note_item(kind, data);
    @(negedge clk);
  endtask

  task automatic run_random(input int count);
    int pick, roll;
    logic [KEY_W-1:0]  name;
    logic [HASH_W-1:0] hash;
    logic [DAY_W-1:0]  change, life, today;
    logic [DAY_W:0]    limit;
    for (int k = 0; k < count; k++) begin
      roll   = $urandom_range(0, 99);
      pick   = $urandom_range(0, POOL - 1);
      name   = present_name(pick);
      hash   = {$urandom, $urandom};
      change = $urandom;
      life   = $urandom;
      today  = $urandom;
      if (roll < 10) begin
        send_item($urandom_range(0, 1) ? KIND_CHECK : KIND_SET, rand_key(), hash,
                  change, life, today);
      end else if (roll < 45) begin
        if ($urandom_range(0, 19) == 0) hash = '0;
        if ($urandom_range(0, 4) == 0) change = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        case ($urandom_range(0, 9))
          0, 1, 2: life = '0;
          3, 4, 5, 6: life = $urandom_range(1, 1000);
          default: ;
        endcase
        if (hash != '0) begin
          pool_known[pick] = 1'b1;
          pool_hash[pick]  = hash;
          pool_day[pick]   = change;
          pool_life[pick]  = life;
        end
        send_item(KIND_SET, name, hash, change, life, today);
      end else begin
        if (pool_known[pick]) begin
          if ($urandom_range(0, 3) != 0) hash = pool_hash[pick];
          // aim today at the expiry boundary most of the time
          limit = {1'b0, pool_day[pick]} + {1'b0, pool_life[pick]};
          case ($urandom_range(0, 4))
            0: limit = limit - 1;
            1: ;
            2: limit = limit + 1;
            default: limit = {1'b0, $urandom};
          endcase
          today = limit[DAY_W] ? '1 : limit[DAY_W-1:0];
        end
        send_item(KIND_CHECK, name, hash, change, life, today);
      end
    end
  endtask

  initial begin
    #6ms;
    $display("credential_expiry_table test failed");
    $finish;
  end

  initial begin
    logic [KEY_W-1:0]  n_ff, n_ff_alt, n_ab, n_ab_g1, n_ab_g2;
    logic [HASH_W-1:0] h1, h2, h3;
    n_ff     = '1;
    n_ff_alt = '1;
    n_ff_alt[8*(KEY_BYTES-1) +: 8] = 8'hFE;
    n_ab     = '0;
    n_ab[15:0] = 16'h6261;
    n_ab_g1  = n_ab | ({KEY_W{1'b1}} << 24);
    n_ab_g2  = n_ab | (KEY_W'(16'hA5C3) << 40);
    h1 = 64'h0123_4567_89AB_CDEF;
    h2 = 64'h8000_0000_0000_0001;
    h3 = 64'h5A5A_F00D_1234_0042;
    for (int i = 0; i < POOL; i++) begin
      pool_len[i]   = ($urandom_range(0, 4) == 0) ? KEY_BYTES : $urandom_range(1, KEY_BYTES - 1);
      pool_key[i]   = '0;
      pool_known[i] = 1'b0;
      for (int b = 0; b < pool_len[i]; b++) pool_key[i][8*b +: 8] = $urandom_range(1, 255);
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty name, zero hash, expiry edges, junk after the name end
    send_item(KIND_CHECK, '0, 64'h1, '0, '0, '0);
    send_item(KIND_SET, '0, '0, '0, '0, '0);
    send_item(KIND_SET, '0, '1, '1, '0, '0);
    send_item(KIND_CHECK, '0, '1, '0, '0, '1);
    send_item(KIND_CHECK, '0, '0, '0, '0, '1);
    send_item(KIND_SET, n_ff, h1, 32'd100, 32'd10, '0);
    send_item(KIND_CHECK, n_ff, h1, '0, '0, 32'd110);
    send_item(KIND_CHECK, n_ff, h1, '0, '0, 32'd111);
    send_item(KIND_CHECK, n_ff, ~h1, '0, '0, 32'd111);
    send_item(KIND_SET, n_ab_g1, h2, '1, '1, '0);
    send_item(KIND_CHECK, n_ab, h2, '0, '0, '1);
    send_item(KIND_SET, n_ab_g2, h3, '0, 32'd1, '0);
    send_item(KIND_CHECK, n_ab_g1, h3, '0, '0, 32'd1);
    send_item(KIND_CHECK, n_ab, h3, '0, '0, 32'd2);
    send_item(KIND_CHECK, n_ab, h2, '0, '0, '0);
    send_item(KIND_CHECK, n_ab_g1, h3, '0, '0, '0);
    send_item(KIND_SET, n_ff, '0, '0, '0, '0);
    send_item(KIND_CHECK, n_ff, h1, '0, '0, '0);
    send_item(KIND_CHECK, n_ff_alt, h1, '0, '0, '0);

    run_random(190);
    idle_pct = 81;
    run_random(190);
    idle_pct  = 0;
    stall_pct = 81;
    run_random(190);
    idle_pct  = 30;
    stall_pct = 30;
    run_random(190);
    in_tvalid <= 1'b0;

    while (board.expected_status.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (board.errors == 0) begin
      $display("credential_expiry_table test passed");
    end else begin
      $display("credential_expiry_table test failed");
    end
    $finish;
  end
endmodule
